/* rtl/fegd_pkg.sv */
// Shared types and constants for the face embedding gallery dedup block.
package fegd_pkg;

  typedef enum logic [2:0] {
    OC_BASE  = 3'd0,
    OC_GAL   = 3'd1,
    OC_SAME  = 3'd2,
    OC_ADD   = 3'd3,
    OC_FRAME = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_TILE_SIZE   = 3'd1,
    CFG_TILE_PAD    = 3'd2,
    CFG_COS_THR     = 3'd3,
    CFG_L2_THR      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] embed_value;
    logic               last_element;
  } in_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [3:0]         match_slot;
    logic signed [15:0] cos_similarity;
    logic [15:0]        l2_distance;
    logic [4:0]         evicted_count;
    logic [4:0]         gallery_count;
  } out_t;

endpackage

/* rtl/face_embedding_gallery_dedup.sv */
// Face embedding gallery dedup: element buffer, cosine/L2 matcher, gallery and eviction.
// Element beats: each is stored, with no result unless the face ends.
// Face end: per candidate a dot product and two norms on the shared 16x16 MAC, two square roots
// when both norms are nonzero, a multiply and divide, a saturate step and an L2 root; a new
// baseline or entry adds an embedding copy. End of frame: one eviction step per evicted entry,
// then the result beat. No beat is taken while a result beat waits.
// Asynchronous active-low reset clears control state; embedding memories are not cleared.
module face_embedding_gallery_dedup #(
  parameter int EMBED_DIM     = 512,
  parameter int GALLERY_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fegd_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fegd_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [fegd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fegd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int IW    = $clog2(EMBED_DIM);
  localparam int NW    = $clog2(EMBED_DIM + 1);
  localparam int SZ_W  = $clog2(GALLERY_DEPTH + 1);
  localparam int GI_W  = (GALLERY_DEPTH > 1) ? $clog2(GALLERY_DEPTH) : 1;
  localparam int GA_W  = $clog2(GALLERY_DEPTH * EMBED_DIM);
  localparam int ACC_W = IW + 32;
  localparam int RW    = ACC_W + (ACC_W % 2);
  localparam int HW    = RW / 2;
  localparam int DW    = ACC_W + 15;
  localparam int CW    = $clog2(DW);
  localparam int EW    = SZ_W + 12;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECIDE = 14'b00000000000010,
    S_CMP    = 14'b00000000000100,
    S_FIN    = 14'b00000000001000,
    S_SQA    = 14'b00000000010000,
    S_SQB    = 14'b00000000100000,
    S_MUL    = 14'b00000001000000,
    S_DIV    = 14'b00000010000000,
    S_SAT    = 14'b00000100000000,
    S_SQL    = 14'b00001000000000,
    S_JUDGE  = 14'b00010000000000,
    S_COPY   = 14'b00100000000000,
    S_EVICT  = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_e;

  state_e state_q;

  logic [12:0]        fw_q;
  logic [9:0]         ts_q;
  logic [7:0]         pad_q;
  logic signed [15:0] cthr_q;
  logic [15:0]        lthr_q;

  logic [IW-1:0]   eidx_q, i_q;
  logic [NW-1:0]   n_q;
  logic [1:0]      ph_q;
  logic            base_valid_q, cmp_gal_q, copy_gal_q;
  logic [GI_W-1:0] head_q;
  logic [SZ_W-1:0] size_q, p_q, ev_q;
  logic [GA_W-1:0] gbase_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] dot_q, na_q, nb_q, nb_fin;
  logic [HW-1:0]   sa_q, sb_q;
  logic [RW-1:0]   den_q;
  logic [DW-1:0]   dvd_q, quo_q;
  logic [RW-1:0]   rem_q;
  logic [CW-1:0]   cnt_q;
  logic            neg_q;
  logic signed [15:0] c_q;
  logic [15:0]     l2_q;
  logic [3:0]      mslot_q;
  fegd_pkg::outcome_e oc_q;
  logic            out_valid_q;
  fegd_pkg::out_t  out_q;

  logic signed [15:0] cur_mem  [EMBED_DIM];
  logic signed [15:0] base_mem [EMBED_DIM];
  logic signed [15:0] gal_mem  [GALLERY_DEPTH*EMBED_DIM];
  logic signed [15:0] cur_rd_q, base_rd_q, gal_rd_q;

  logic in_acc, cur_we, base_we, gal_we;
  logic signed [15:0] x_val, y_val, mul_a, mul_b;
  logic [GA_W-1:0] gaddr;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 13'd1920;
      ts_q   <= 10'd128;
      pad_q  <= 8'd10;
      cthr_q <= 16'sd16384;
      lthr_q <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fegd_pkg::CFG_FRAME_WIDTH: fw_q   <= cfg_data_i[12:0];
        fegd_pkg::CFG_TILE_SIZE:   ts_q   <= cfg_data_i[9:0];
        fegd_pkg::CFG_TILE_PAD:    pad_q  <= cfg_data_i[7:0];
        fegd_pkg::CFG_COS_THR:     cthr_q <= cfg_data_i;
        fegd_pkg::CFG_L2_THR:      lthr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memories
  assign x_val   = (NW'(i_q) < n_q) ? cur_rd_q : 16'sd0;
  assign y_val   = cmp_gal_q ? gal_rd_q : base_rd_q;
  assign cur_we  = in_acc && !in_data_i.cmd;
  assign base_we = (state_q == S_COPY) && ph_q[0] && !copy_gal_q;
  assign gal_we  = (state_q == S_COPY) && ph_q[0] && copy_gal_q;
  assign gaddr   = gbase_q + GA_W'(i_q);

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[eidx_q] <= in_data_i.embed_value;
    cur_rd_q <= cur_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[i_q] <= x_val;
    base_rd_q <= base_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (gal_we) gal_mem[gaddr] <= x_val;
    gal_rd_q <= gal_mem[gaddr];
  end

  // shared MAC operands
  always_comb begin
    mul_a = x_val;
    mul_b = y_val;
    case (ph_q)
      2'd2:    mul_b = x_val;
      2'd3:    mul_a = y_val;
      default: ;
    endcase
  end

  assign nb_fin = nb_q + ACC_W'(prod_q);

  // slot arithmetic
  logic [SZ_W-1:0] off;
  logic [SZ_W:0]   wsum;
  logic [GI_W-1:0] slot, head_inc;
  logic            full;
  assign off      = (state_q == S_DECIDE) ? p_q : size_q;
  assign full     = (size_q == SZ_W'(GALLERY_DEPTH));
  assign head_inc = (head_q == GI_W'(GALLERY_DEPTH - 1)) ? '0 : head_q + 1'b1;
  always_comb begin
    wsum = (SZ_W+1)'(head_q) + (SZ_W+1)'(off);
    if (wsum >= (SZ_W+1)'(GALLERY_DEPTH)) wsum = wsum - (SZ_W+1)'(GALLERY_DEPTH);
    slot = GI_W'(wsum);
  end

  // divide, saturate, l2 radicand
  logic [RW:0]     rem_sh;
  logic            rem_ge;
  logic [ACC_W-1:0] mag;
  logic signed [15:0] c_sat;
  logic [17:0]     l2v;
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign mag    = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
  always_comb begin
    if (neg_q) c_sat = (quo_q > DW'(32768)) ? -16'sd32768 : 16'(~quo_q[16:0] + 17'd1);
    else       c_sat = (quo_q > DW'(32767)) ? 16'sd32767 : quo_q[15:0];
  end
  assign l2v = 18'h10000 - {c_sat[15], c_sat, 1'b0};

  // square root unit
  logic          sq_start, sq_done;
  logic [RW-1:0] sq_rad;
  logic [HW-1:0] sq_root;
  logic          nz;
  assign nz = (na_q != '0) && (nb_fin != '0);
  always_comb begin
    sq_start = 1'b0;
    sq_rad   = RW'(na_q);
    unique case (state_q)
      S_FIN: sq_start = nz;
      S_SQA: begin
        sq_start = sq_done;
        sq_rad   = RW'(nb_q);
      end
      S_SAT: begin
        sq_start = 1'b1;
        sq_rad   = RW'({l2v, 13'd0});
      end
      default: ;
    endcase
  end

  fegd_isqrt #(.RW(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // eviction test
  logic [EW-1:0] ev_need;
  logic          ev_go;
  assign ev_need = EW'(size_q) * EW'(11'(ts_q) + 11'(pad_q)) + EW'(pad_q);
  assign ev_go   = (size_q != '0) && (ev_need >= EW'(fw_q));

  logic match;
  assign match = (17'(c_q) >= 17'(cthr_q)) || (l2_q <= lthr_q);

  logic [SZ_W+3:0] mslot_w, gcnt_w, ev_w;
  logic [SZ_W-1:0] size_new;
  assign size_new = full ? size_q : size_q + 1'b1;
  assign gcnt_w   = (SZ_W+4)'(size_q);
  assign ev_w     = (SZ_W+4)'(ev_q);

  always_comb begin
    mslot_w = '0;
    if (cmp_gal_q) mslot_w = (SZ_W+4)'(p_q);
    else           mslot_w = (SZ_W+4)'(size_new - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      eidx_q       <= '0;
      base_valid_q <= 1'b0;
      head_q       <= '0;
      size_q       <= '0;
      out_valid_q  <= 1'b0;
      ph_q         <= '0;
      i_q          <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.cmd) begin
              eidx_q  <= '0;
              ev_q    <= '0;
              state_q <= S_EVICT;
            end else if (in_data_i.last_element || eidx_q == IW'(EMBED_DIM - 1)) begin
              n_q     <= NW'(eidx_q) + 1'b1;
              eidx_q  <= '0;
              p_q     <= '0;
              state_q <= S_DECIDE;
            end else begin
              eidx_q <= eidx_q + 1'b1;
            end
          end
        end
        S_DECIDE: begin
          i_q  <= '0;
          ph_q <= '0;
          if (!base_valid_q) begin
            copy_gal_q <= 1'b0;
            cmp_gal_q  <= 1'b0;
            oc_q       <= fegd_pkg::OC_BASE;
            state_q    <= S_COPY;
          end else begin
            cmp_gal_q <= (p_q < size_q);
            gbase_q   <= GA_W'(slot) * GA_W'(EMBED_DIM);
            dot_q     <= '0;
            na_q      <= '0;
            nb_q      <= '0;
            prod_q    <= '0;
            state_q   <= S_CMP;
          end
        end
        S_CMP: begin
          case (ph_q)
            2'd0: begin
              nb_q <= nb_fin;
              ph_q <= 2'd1;
            end
            2'd1: begin
              prod_q <= mul_a * mul_b;
              ph_q   <= 2'd2;
            end
            2'd2: begin
              dot_q  <= dot_q + ACC_W'(prod_q);
              prod_q <= mul_a * mul_b;
              ph_q   <= 2'd3;
            end
            default: begin
              na_q   <= na_q + ACC_W'(prod_q);
              prod_q <= mul_a * mul_b;
              ph_q   <= 2'd0;
              if (i_q == IW'(EMBED_DIM - 1)) state_q <= S_FIN;
              else i_q <= i_q + 1'b1;
            end
          endcase
        end
        S_FIN: begin
          nb_q  <= nb_fin;
          neg_q <= dot_q[ACC_W-1];
          if (nz) begin
            state_q <= S_SQA;
          end else begin
            c_q     <= '0;
            l2_q    <= ((na_q == '0) && (nb_fin == '0)) ? 16'd0 : 16'd16384;
            state_q <= S_JUDGE;
          end
        end
        S_SQA: begin
          if (sq_done) begin
            sa_q    <= sq_root;
            state_q <= S_SQB;
          end
        end
        S_SQB: begin
          if (sq_done) begin
            sb_q    <= sq_root;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          den_q   <= RW'(sa_q) * RW'(sb_q);
          dvd_q   <= {mag, 15'd0};
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_ge ? RW'(rem_sh - {1'b0, den_q}) : RW'(rem_sh);
          quo_q <= {quo_q[DW-2:0], rem_ge};
          dvd_q <= dvd_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(DW - 1)) state_q <= S_SAT;
        end
        S_SAT: begin
          c_q     <= c_sat;
          state_q <= S_SQL;
        end
        S_SQL: begin
          if (sq_done) begin
            l2_q    <= sq_root[15:0];
            state_q <= S_JUDGE;
          end
        end
        S_JUDGE: begin
          mslot_q <= mslot_w[3:0];
          if (cmp_gal_q) begin
            if (match) begin
              oc_q    <= fegd_pkg::OC_GAL;
              state_q <= S_EMIT;
            end else begin
              p_q     <= p_q + 1'b1;
              state_q <= S_DECIDE;
            end
          end else if (match) begin
            oc_q    <= fegd_pkg::OC_SAME;
            state_q <= S_EMIT;
          end else begin
            if (full) head_q <= head_inc;
            size_q     <= size_new;
            gbase_q    <= GA_W'(slot) * GA_W'(EMBED_DIM);
            copy_gal_q <= 1'b1;
            i_q        <= '0;
            ph_q       <= '0;
            oc_q       <= fegd_pkg::OC_ADD;
            state_q    <= S_COPY;
          end
        end
        S_COPY: begin
          if (!ph_q[0]) begin
            ph_q <= 2'd1;
          end else begin
            ph_q <= 2'd0;
            if (i_q == IW'(EMBED_DIM - 1)) begin
              if (!copy_gal_q) base_valid_q <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        S_EVICT: begin
          if (ev_go) begin
            head_q <= head_inc;
            size_q <= size_q - 1'b1;
            ev_q   <= ev_q + 1'b1;
          end else begin
            oc_q    <= fegd_pkg::OC_FRAME;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q             <= 1'b1;
            out_q.outcome           <= oc_q;
            out_q.match_slot        <= (oc_q == fegd_pkg::OC_GAL || oc_q == fegd_pkg::OC_ADD)
                                       ? mslot_q : 4'd0;
            out_q.cos_similarity    <= (oc_q == fegd_pkg::OC_SAME || oc_q == fegd_pkg::OC_ADD)
                                       ? c_q : 16'sd0;
            out_q.l2_distance       <= (oc_q == fegd_pkg::OC_SAME || oc_q == fegd_pkg::OC_ADD)
                                       ? l2_q : 16'd0;
            out_q.evicted_count     <= (oc_q == fegd_pkg::OC_FRAME) ? ev_w[4:0] : 5'd0;
            out_q.gallery_count     <= gcnt_w[4:0];
            state_q                 <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/fegd_isqrt.sv */
// Bit-serial floor square root, two radicand bits per cycle.
module fegd_isqrt #(
  parameter int RW = 44
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RW-1:0]     rad_i,
  output logic              done_o,
  output logic [RW/2-1:0]   root_o
);

  localparam int HW = RW / 2;
  localparam int KW = $clog2(HW);

  logic [RW-1:0] x_q, res_q, bit_q, sum;
  logic [KW-1:0] cnt_q;
  logic          busy_q, done_q;

  assign sum    = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == KW'(HW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= rad_i;
      res_q <= '0;
      bit_q <= {2'b01, {(RW-2){1'b0}}};
      cnt_q <= '0;
    end else if (busy_q) begin
      if (x_q >= sum) begin
        x_q   <= x_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q + 1'b1;
    end
  end

endmodule

/* rtl/fegd_checker.sv */
// Port-level checks for the gallery dedup block, bound to the top level.
module fegd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input fegd_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fegd_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == fegd_pkg::OC_FRAME |->
      out_data_o.match_slot == 4'd0 && out_data_o.cos_similarity == 16'sd0 &&
      out_data_o.l2_distance == 16'd0)
    else $error("frame close beat carries match fields");

  a_evict_only_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome != fegd_pkg::OC_FRAME |->
      out_data_o.evicted_count == 5'd0)
    else $error("eviction count outside frame close");

  a_mid_face_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.cmd && !in_data_i.last_element |=>
      !out_valid_o)
    else $error("result after a mid-face element");

endmodule

bind face_embedding_gallery_dedup fegd_checker u_fegd_checker (.*);
